// ===== rtl/core/met_pkg.sv =====
package met_pkg;

  // Fraction bits of the fixed point format used for plane coordinates.
  localparam int FRAC_BITS = 28;

  localparam int CFG_W   = 32;
  localparam int IDX_W   = 3;
  localparam int SIZE_W  = 13;
  localparam int HSPAN_W = 31;

  localparam logic [IDX_W-1:0] REG_CENTER_X   = 3'd0;
  localparam logic [IDX_W-1:0] REG_CENTER_Y   = 3'd1;
  localparam logic [IDX_W-1:0] REG_HALF_SPAN  = 3'd2;
  localparam logic [IDX_W-1:0] REG_IMG_WIDTH  = 3'd3;
  localparam logic [IDX_W-1:0] REG_IMG_HEIGHT = 3'd4;
  localparam logic [IDX_W-1:0] REG_MAX_ITER   = 3'd5;

  typedef struct packed {
    logic [31:0]        center_x;
    logic [31:0]        center_y;
    logic [HSPAN_W-1:0] half_span;
    logic [SIZE_W-1:0]  img_width;
    logic [SIZE_W-1:0]  img_height;
  } map_cfg_t;

endpackage

// ===== rtl/core/met_div.sv =====
module met_div #(
  parameter int NW = 44,
  parameter int DW = 13
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [NW-1:0] quot_o
);

  localparam int CNTW = $clog2(NW + 1);

  logic [NW-1:0]   quo_q;
  logic [DW-1:0]   rem_q;
  logic [DW-1:0]   dsr_q;
  logic [CNTW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [DW:0]     trial;
  logic            ge;
  logic [DW-1:0]   rem_d;

  // Restoring division, one quotient bit per cycle, MSB first.
  always_comb begin
    trial = {rem_q, quo_q[NW-1]};
    ge    = trial >= {1'b0, dsr_q};
    rem_d = ge ? DW'(trial - {1'b0, dsr_q}) : trial[DW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NW-2:0], ge};
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ===== rtl/core/met_fifo.sv =====
module met_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  output logic         push_ready_o,
  input  logic [W-1:0] push_data_i,
  output logic         pop_valid_o,
  input  logic         pop_ready_i,
  output logic [W-1:0] pop_data_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0] mem_q [DEPTH];
  logic [AW-1:0] wptr_q, rptr_q;
  logic [AW:0]   cnt_q;
  logic          push, pop;

  assign push_ready_o = cnt_q != (AW+1)'(DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/met_front.sv =====
module met_front #(
  parameter int CW  = 12,
  parameter int CXW = 46
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  met_pkg::map_cfg_t     cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [CW-1:0]         col_i,
  input  logic [CW-1:0]         row_i,
  output logic                  push_valid_o,
  input  logic                  push_ready_i,
  output logic [CW-1:0]         col_o,
  output logic [CW-1:0]         row_o,
  output logic signed [CXW-1:0] c_re_o,
  output logic signed [CXW-1:0] c_im_o
);

  localparam int NW = CW + 32;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [CW-1:0] col_q, row_q;
  logic signed [32:0] base_x_q, base_y_q;
  logic [31:0] span2;
  logic [met_pkg::SIZE_W-1:0] div_x, div_y;
  logic [NW-1:0] dvd_x, dvd_y, quo_x, quo_y;
  logic done_x, done_y, accept;

  assign in_ready_o = state_q == ST_IDLE;
  assign accept     = in_valid_i && in_ready_o;
  assign span2      = {cfg_i.half_span, 1'b0};
  assign div_x      = (cfg_i.img_width == '0) ? met_pkg::SIZE_W'(1) : cfg_i.img_width;
  assign div_y      = (cfg_i.img_height == '0) ? met_pkg::SIZE_W'(1) : cfg_i.img_height;
  assign dvd_x      = NW'(col_i * span2);
  assign dvd_y      = NW'(row_i * span2);

  met_div #(.NW(NW), .DW(met_pkg::SIZE_W)) u_div_x (
    .clk_i, .rst_ni, .start_i(accept), .dividend_i(dvd_x), .divisor_i(div_x),
    .done_o(done_x), .quot_o(quo_x)
  );

  met_div #(.NW(NW), .DW(met_pkg::SIZE_W)) u_div_y (
    .clk_i, .rst_ni, .start_i(accept), .dividend_i(dvd_y), .divisor_i(div_y),
    .done_o(done_y), .quot_o(quo_y)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      col_q    <= col_i;
      row_q    <= row_i;
      base_x_q <= {cfg_i.center_x[31], cfg_i.center_x} - {2'b00, cfg_i.half_span};
      base_y_q <= {cfg_i.center_y[31], cfg_i.center_y} - {2'b00, cfg_i.half_span};
    end
  end

  // Both dividers run the same number of steps, so they finish together.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_DIV;
      ST_DIV:  if (done_x && done_y) state_d = ST_PUSH;
      ST_PUSH: if (push_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign push_valid_o = state_q == ST_PUSH;
  assign col_o  = col_q;
  assign row_o  = row_q;
  assign c_re_o = $signed({{(CXW-33){base_x_q[32]}}, base_x_q})
                + $signed({{(CXW-NW){1'b0}}, quo_x});
  assign c_im_o = $signed({{(CXW-33){base_y_q[32]}}, base_y_q})
                + $signed({{(CXW-NW){1'b0}}, quo_y});

endmodule

// ===== rtl/core/met_back.sv =====
module met_back #(
  parameter int CW  = 12,
  parameter int IW  = 16,
  parameter int CXW = 46
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [IW-1:0]         limit_i,
  input  logic                  pop_valid_i,
  output logic                  pop_ready_o,
  input  logic [CW-1:0]         col_i,
  input  logic [CW-1:0]         row_i,
  input  logic signed [CXW-1:0] c_re_i,
  input  logic signed [CXW-1:0] c_im_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [CW-1:0]         col_o,
  output logic [CW-1:0]         row_o,
  output logic [IW-1:0]         count_o,
  output logic [7:0]            gray_o
);

  localparam int FB  = met_pkg::FRAC_BITS;
  localparam int OPW = FB + 3;
  localparam int PW  = 2 * OPW;
  localparam int SQW = PW - FB;
  localparam logic signed [CXW-1:0] TWO  = CXW'(64'd2 << FB);
  localparam logic signed [CXW-1:0] MTWO = -TWO;
  localparam logic [SQW:0]          FOUR = (SQW+1)'(64'd4 << FB);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CHK  = 3'd1;
  localparam logic [2:0] ST_UPD  = 3'd2;
  localparam logic [2:0] ST_GRAY = 3'd3;
  localparam logic [2:0] ST_WAIT = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0] state_q, state_d;
  logic signed [CXW-1:0] x_q, y_q, cre_q, cim_q;
  logic signed [SQW-1:0] xx_q, yy_q, xy_q;
  logic signed [PW-1:0]  pxx, pyy, pxy;
  logic [CW-1:0] col_q, row_q;
  logic [IW-1:0] n_q;
  logic [7:0]    gray_q;
  logic          outside, stop, escaped, pop, gdone, gstart;
  logic [SQW:0]  mag;
  logic [IW+7:0] gdvd, gquo;

  assign pop     = pop_valid_i && pop_ready_o;
  assign pop_ready_o = state_q == ST_IDLE;
  assign outside = (x_q > TWO) || (x_q < MTWO) || (y_q > TWO) || (y_q < MTWO);
  assign stop    = (n_q >= limit_i) || outside;
  // Both squares are non-negative after flooring, so the magnitude is an unsigned sum.
  assign mag     = {xx_q[SQW-1], xx_q} + {yy_q[SQW-1], yy_q};
  assign escaped = mag > FOUR;

  // Inside the bounds checked above, both parts fit in OPW signed bits.
  assign pxx = $signed(x_q[OPW-1:0]) * $signed(x_q[OPW-1:0]);
  assign pyy = $signed(y_q[OPW-1:0]) * $signed(y_q[OPW-1:0]);
  assign pxy = $signed(x_q[OPW-1:0]) * $signed(y_q[OPW-1:0]);

  assign gstart = (state_q == ST_GRAY) && (limit_i != '0);
  assign gdvd   = {n_q, 8'd0} - {8'd0, n_q};

  met_div #(.NW(IW + 8), .DW(IW)) u_div_gray (
    .clk_i, .rst_ni, .start_i(gstart), .dividend_i(gdvd), .divisor_i(limit_i),
    .done_o(gdone), .quot_o(gquo)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (pop) state_d = ST_CHK;
      ST_CHK:  state_d = stop ? ST_GRAY : ST_UPD;
      ST_UPD:  state_d = escaped ? ST_GRAY : ST_CHK;
      ST_GRAY: state_d = (limit_i == '0) ? ST_OUT : ST_WAIT;
      ST_WAIT: if (gdone) state_d = ST_OUT;
      ST_OUT:  if (out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (pop) begin
          x_q   <= c_re_i;
          y_q   <= c_im_i;
          cre_q <= c_re_i;
          cim_q <= c_im_i;
          col_q <= col_i;
          row_q <= row_i;
          n_q   <= '0;
        end
      end
      ST_CHK: begin
        xx_q <= pxx[PW-1:FB];
        yy_q <= pyy[PW-1:FB];
        xy_q <= pxy[PW-1:FB];
      end
      ST_UPD: begin
        if (!escaped) begin
          x_q <= CXW'(xx_q) - CXW'(yy_q) + cre_q;
          y_q <= (CXW'(xy_q) <<< 1) + cim_q;
          n_q <= n_q + 1'b1;
        end
      end
      ST_GRAY: gray_q <= '0;
      ST_WAIT: if (gdone) gray_q <= gquo[7:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign out_valid_o = state_q == ST_OUT;
  assign col_o   = col_q;
  assign row_o   = row_q;
  assign count_o = n_q;
  assign gray_o  = gray_q;

endmodule

// ===== rtl/core/mandelbrot_escape_time_gray_top.sv =====
// Escape-time evaluator for the Mandelbrot set with a gray level per pixel.
// The slave stream takes one request per pixel: a column and a row index.
// The pixel is mapped onto the complex plane from the configured center,
// half span and image size, then z = z*z + c is iterated in signed fixed point
// until a coordinate leaves [-2, 2], |z|^2 exceeds four or the iteration limit is reached.
// The master stream returns the pixel indices, the iteration count and the
// gray level 255*count/limit, one result per request and in request order.
// Configuration is to be written through cfg_we_i, cfg_index_i and cfg_data_i only
// while the block is idle, which the block itself does not enforce; the registers take effect for the next request.
// The front end maps a pixel with its two bit-serial dividers and hands it
// to a two-entry queue. The back end runs each iteration in two steps
// (multiply, then add and compare) and, when the limit is nonzero, ends a
// pixel with a bit-serial gray division. Mapping of the next pixels
// overlaps the iteration of the current one.
// Reset clears all control state and loads the default view.
// When the receiver stalls, the result is held on the master stream and the
// back end waits; the front end keeps filling the queue until it is full.
module mandelbrot_escape_time_gray_top #(
  parameter int COORD_WIDTH = 12,
  parameter int ITER_WIDTH  = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic                              cfg_we_i,
  input  logic [met_pkg::IDX_W-1:0]         cfg_index_i,
  input  logic [met_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // Fields from bit 0 up: column, row, zero padding.
  input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // Fields from bit 0 up: out_column, out_row, iteration_count, gray_level, padding.
  output logic [((2*COORD_WIDTH+ITER_WIDTH+8+7)/8)*8-1:0] m_axis_tdata
);

  localparam int CW     = COORD_WIDTH;
  localparam int IW     = ITER_WIDTH;
  localparam int CXW    = CW + 34;
  localparam int OUT_TW = ((2*CW + IW + 8 + 7) / 8) * 8;
  localparam int QW     = 2*CW + 2*CXW;

  met_pkg::map_cfg_t cfg_q;
  logic [IW-1:0]     limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_x   <= '0;
      cfg_q.center_y   <= '0;
      cfg_q.half_span  <= met_pkg::HSPAN_W'(1073741824);
      cfg_q.img_width  <= met_pkg::SIZE_W'(500);
      cfg_q.img_height <= met_pkg::SIZE_W'(500);
      limit_q          <= IW'(1000);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        met_pkg::REG_CENTER_X:   cfg_q.center_x   <= cfg_data_i;
        met_pkg::REG_CENTER_Y:   cfg_q.center_y   <= cfg_data_i;
        met_pkg::REG_HALF_SPAN:  cfg_q.half_span  <= cfg_data_i[met_pkg::HSPAN_W-1:0];
        met_pkg::REG_IMG_WIDTH:  cfg_q.img_width  <= cfg_data_i[met_pkg::SIZE_W-1:0];
        met_pkg::REG_IMG_HEIGHT: cfg_q.img_height <= cfg_data_i[met_pkg::SIZE_W-1:0];
        met_pkg::REG_MAX_ITER:   limit_q          <= cfg_data_i[IW-1:0];
        default: ;
      endcase
    end
  end

  logic f_valid, f_ready, q_valid, q_ready;
  logic [CW-1:0] f_col, f_row, q_col, q_row, o_col, o_row;
  logic signed [CXW-1:0] f_re, f_im;
  logic [QW-1:0] q_data;
  logic [IW-1:0] o_cnt;
  logic [7:0]    o_gray;

  met_front #(.CW(CW), .CXW(CXW)) u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .col_i(s_axis_tdata[CW-1:0]), .row_i(s_axis_tdata[2*CW-1:CW]),
    .push_valid_o(f_valid), .push_ready_i(f_ready),
    .col_o(f_col), .row_o(f_row), .c_re_o(f_re), .c_im_o(f_im)
  );

  met_fifo #(.W(QW), .DEPTH(2)) u_queue (
    .clk_i, .rst_ni,
    .push_valid_i(f_valid), .push_ready_o(f_ready),
    .push_data_i({f_im, f_re, f_row, f_col}),
    .pop_valid_o(q_valid), .pop_ready_i(q_ready), .pop_data_o(q_data)
  );

  assign q_col = q_data[CW-1:0];
  assign q_row = q_data[2*CW-1:CW];

  met_back #(.CW(CW), .IW(IW), .CXW(CXW)) u_back (
    .clk_i, .rst_ni, .limit_i(limit_q),
    .pop_valid_i(q_valid), .pop_ready_o(q_ready),
    .col_i(q_col), .row_i(q_row),
    .c_re_i($signed(q_data[2*CW+CXW-1:2*CW])),
    .c_im_i($signed(q_data[QW-1:2*CW+CXW])),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .col_o(o_col), .row_o(o_row), .count_o(o_cnt), .gray_o(o_gray)
  );

  assign m_axis_tdata = OUT_TW'({o_gray, o_cnt, o_row, o_col});

endmodule

// ===== rtl/core/met_chk.sv =====
module met_chk #(
  parameter int COORD_WIDTH = 12,
  parameter int ITER_WIDTH  = 16
) (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [((2*COORD_WIDTH+ITER_WIDTH+8+7)/8)*8-1:0] m_axis_tdata
);

  localparam int CB = 2 * COORD_WIDTH;
  localparam int GB = CB + ITER_WIDTH;

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // No result is offered while reset is held.
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid)
    else $error("result offered in reset");

  // A pixel that made no step has gray level zero.
  a_zero_gray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[GB-1:CB] == '0) |-> m_axis_tdata[GB+7:GB] == '0)
    else $error("nonzero gray for zero count");

  // Just after a request is taken the front end is busy mapping it.
  a_front_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second request taken during mapping");

endmodule

bind mandelbrot_escape_time_gray_top met_chk #(
  .COORD_WIDTH(COORD_WIDTH),
  .ITER_WIDTH(ITER_WIDTH)
) u_met_chk (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);

// ===== bench/mandelbrot_escape_time_gray_top_tb.sv =====
`timescale 1ns / 100ps

module mandelbrot_escape_time_gray_top_tb;

  localparam int COORD_W   = 12;
  localparam int ITER_W    = 16;
  localparam int SDATA_W   = ((2*COORD_W+7)/8)*8;
  localparam int MDATA_W   = ((2*COORD_W+ITER_W+8+7)/8)*8;
  localparam int CYCLE_CAP = 3000000;
  localparam int HOLD_LEN  = 3000;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i = 1'b0;
  logic [met_pkg::IDX_W-1:0] cfg_index_i = '0;
  logic [met_pkg::CFG_W-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [SDATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [MDATA_W-1:0] m_axis_tdata;

  mandelbrot_escape_time_gray_top #(.COORD_WIDTH(COORD_W), .ITER_WIDTH(ITER_W)) dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  typedef struct {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [ITER_W-1:0]  count;
    logic [7:0]         gray;
  } pixel_result_t;

  // Holds a private copy of the view registers, computes the escape time of
  // every accepted pixel request and compares results in arrival order.
  class escape_scoreboard;
    logic [31:0]                 cx, cy;
    logic [met_pkg::HSPAN_W-1:0] hspan;
    logic [met_pkg::SIZE_W-1:0]  width, height;
    logic [ITER_W-1:0]           limit;
    pixel_result_t               pending_px[$];
    int                          fails;

    function new();
      cx = '0; cy = '0; hspan = 31'd1073741824;
      width = 13'd500; height = 13'd500; limit = 16'd1000;
      fails = 0;
    endfunction

    function void set_reg(logic [met_pkg::IDX_W-1:0] idx, logic [met_pkg::CFG_W-1:0] val);
      case (idx)
        met_pkg::REG_CENTER_X:   cx = val;
        met_pkg::REG_CENTER_Y:   cy = val;
        met_pkg::REG_HALF_SPAN:  hspan = val[met_pkg::HSPAN_W-1:0];
        met_pkg::REG_IMG_WIDTH:  width = val[met_pkg::SIZE_W-1:0];
        met_pkg::REG_IMG_HEIGHT: height = val[met_pkg::SIZE_W-1:0];
        met_pkg::REG_MAX_ITER:   limit = val[ITER_W-1:0];
        default: ;
      endcase
    endfunction

    // Exact product, then the fraction bits are dropped (floor).
    function longint qmul(longint a, longint b);
      logic signed [127:0] p;
      p = a * b;
      return longint'(p >>> met_pkg::FRAC_BITS);
    endfunction

    // A zero size counts as one; indices past the size extrapolate.
    function longint map_axis(logic [31:0] ctr, logic [COORD_W-1:0] idx,
                              logic [met_pkg::SIZE_W-1:0] size);
      logic [63:0] offs;
      logic [63:0] div;
      div = (size == 0) ? 64'd1 : 64'(size);
      offs = (64'(idx) * (64'(hspan) * 64'd2)) / div;
      return longint'($signed(ctr)) - longint'(hspan) + longint'(offs);
    endfunction

    function void note_pixel(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
      longint cre, cim, x, y, xx, yy, xy, two, four;
      int unsigned n;
      pixel_result_t px;
      two = longint'(2) <<< met_pkg::FRAC_BITS;
      four = longint'(4) <<< met_pkg::FRAC_BITS;
      cre = map_axis(cx, col, width);
      cim = map_axis(cy, row, height);
      x = cre; y = cim; n = 0;
      while (n < limit) begin
        // A coordinate beyond two has escaped before any square is formed.
        if (x > two || x < -two || y > two || y < -two) break;
        xx = qmul(x, x);
        yy = qmul(y, y);
        if (xx + yy > four) break;
        xy = qmul(x, y);
        x = xx - yy + cre;
        y = 2 * xy + cim;
        n++;
      end
      px.col = col;
      px.row = row;
      px.count = n[ITER_W-1:0];
      px.gray = (limit == 0) ? 8'd0 : 8'((255 * n) / limit);
      pending_px.push_back(px);
    endfunction

    function void check_result(logic [MDATA_W-1:0] d);
      pixel_result_t e;
      if (pending_px.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $time, d);
        fails++;
        return;
      end
      e = pending_px.pop_front();
      if (d[11:0] !== e.col) begin
        $display("%0t: out_column expected %0d actual %0d", $time, e.col, d[11:0]);
        fails++;
      end
      if (d[23:12] !== e.row) begin
        $display("%0t: out_row expected %0d actual %0d", $time, e.row, d[23:12]);
        fails++;
      end
      if (d[39:24] !== e.count) begin
        $display("%0t: iteration_count expected %0d actual %0d", $time, e.count, d[39:24]);
        fails++;
      end
      if (d[47:40] !== e.gray) begin
        $display("%0t: gray_level expected %0d actual %0d", $time, e.gray, d[47:40]);
        fails++;
      end
    endfunction
  endclass

  escape_scoreboard sb = new();

  // Handshake signals are driven at the rising edge and are stable by the
  // falling edge, so both streams are observed there, free of races.
  always @(negedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      sb.note_pixel(s_axis_tdata[11:0], s_axis_tdata[23:12]);
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata);
  end

  int cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: random stalls per result, stall-free stretches when asked, and
  // one long hold-off after the first hundred results so the input backs up.
  bit rx_no_idle = 1'b0;
  int results_seen = 0;
  bit held = 1'b0;
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = rx_no_idle ? 0 : $urandom_range(0, 12);
      if (!held && results_seen >= 100) begin
        held = 1'b1;
        gap = HOLD_LEN;
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(negedge clk_i); while (!m_axis_tvalid);
      @(posedge clk_i);
      results_seen++;
    end
  end

  bit tx_no_idle = 1'b0;

  // Offers one pixel request and returns at the edge that accepts it.
  task automatic send_pixel(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
    int gap;
    gap = tx_no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {row, col};
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
  endtask

  // Drains all outstanding results, lets the mapping front end settle, and
  // only then touches the registers.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_px.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [met_pkg::IDX_W-1:0] idx, logic [met_pkg::CFG_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  task automatic set_view(logic [31:0] cx, logic [31:0] cy, logic [31:0] hs,
                          logic [31:0] w, logic [31:0] h, logic [31:0] lim);
    wait_idle();
    write_reg(met_pkg::REG_CENTER_X, cx);
    write_reg(met_pkg::REG_CENTER_Y, cy);
    write_reg(met_pkg::REG_HALF_SPAN, hs);
    write_reg(met_pkg::REG_IMG_WIDTH, w);
    write_reg(met_pkg::REG_IMG_HEIGHT, h);
    write_reg(met_pkg::REG_MAX_ITER, lim);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int w, h;
    logic [COORD_W-1:0] col, row;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Default view: corners, a point deep inside the set, and pixels past
    // the image edge, which extrapolate the mapping.
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd250, 12'd250);
    send_pixel(12'd499, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd4095);

    // Small limit with a near-origin view.
    set_view(32'hF800_0000, 32'h0, 32'h1000_0000, 32'd8, 32'd8, 32'd20);
    for (int i = 0; i < 8; i++) send_pixel(12'(i), 12'(7 - i));

    // A zero iteration limit does no step and yields a zero gray level.
    set_view(32'h0, 32'h0, 32'h1000_0000, 32'd4, 32'd4, 32'd0);
    send_pixel(12'd1, 12'd2);

    // Zero image sizes divide by one; a zero half span maps every pixel to
    // the center.
    set_view(32'hF000_0000, 32'h0800_0000, 32'h0, 32'd0, 32'd0, 32'd50);
    send_pixel(12'd3, 12'd4095);
    send_pixel(12'd4095, 12'd0);

    // Extreme center and span: everything escapes at once, so the largest
    // limit stays cheap; the sizes take their widest encodings too.
    set_view(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h1FFF, 32'd4096,
             32'hFFFF_FFFF);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd2048, 12'd1024);

    // One pixel inside the set at the largest limit.
    set_view(32'h0, 32'h0, 32'h0000_0100, 32'd1, 32'd1, 32'd65535);
    send_pixel(12'd0, 12'd0);

    // Random phases: mostly views around the set with small limits, some with
    // raw random register words.
    for (int ph = 0; ph < 12; ph++) begin
      if (ph % 4 == 3)
        set_view($urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom & 32'hFFFF_007F);
      else
        set_view(32'($urandom_range(0, 32'h3000_0000)) - 32'h2000_0000,
                 32'($urandom_range(0, 32'h2000_0000)) - 32'h1000_0000,
                 $urandom_range(32'h0010_0000, 32'h2000_0000),
                 $urandom_range(1, 64), $urandom_range(1, 64),
                 $urandom_range(1, 80));
      tx_no_idle = (ph % 3 == 1);
      rx_no_idle = (ph % 3 == 1);
      w = (sb.width == 0) ? 1 : sb.width;
      h = (sb.height == 0) ? 1 : sb.height;
      for (int i = 0; i < 50; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          col = $urandom;
          row = $urandom;
        end else begin
          col = $urandom_range(0, (w > 4096 ? 4096 : w) - 1);
          row = $urandom_range(0, (h > 4096 ? 4096 : h) - 1);
        end
        send_pixel(col, row);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (sb.pending_px.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (sb.fails == 0 && sb.pending_px.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ===== mandelbrot_escape_time_gray_top.f =====
rtl/core/met_pkg.sv
rtl/core/met_div.sv
rtl/core/met_fifo.sv
rtl/core/met_front.sv
rtl/core/met_back.sv
rtl/core/mandelbrot_escape_time_gray_top.sv
rtl/core/met_chk.sv
bench/mandelbrot_escape_time_gray_top_tb.sv
